// ===== rtl/wsts_pkg.sv =====
package wsts_pkg;

  localparam int NumWorkersDef  = 4;
  localparam int DequeDepthDef  = 256;
  localparam int ExtDepthDef    = 1024;
  localparam int TokenWidthDef  = 32;
  localparam logic [31:0] SeedMul = 32'd2654435761;

  localparam logic OP_SUBMIT = 1'b0;
  localparam logic OP_FETCH  = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  localparam logic [1:0] SRC_OWN   = 2'd0;
  localparam logic [1:0] SRC_EXT   = 2'd1;
  localparam logic [1:0] SRC_STEAL = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic latch_req;   // capture the input word
    logic decide;      // pick action, update pointers, launch memory read/write
    logic steal_step;  // test next peer in steal scan
    logic capture;     // hold the token returned by the memory read
    logic finish;      // load result register
  } wsts_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_read;   // decision launched a memory read
    logic go_steal;    // decision entered steal scan
    logic steal_hit;   // current peer has work (read launched)
    logic steal_done;  // scan exhausted with no hit
  } wsts_sts_t;

  function automatic logic [31:0] xorshift32(input logic [31:0] s);
    logic [31:0] x;
    x = s ^ (s << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

endpackage

// ===== rtl/work_stealing_task_scheduler_unit.sv =====
// Work-stealing task scheduler: one bounded deque per worker plus a shared FIFO.
// Input stream s_axis: one word per request (submit or fetch).
// Output stream m_axis: exactly one result word per request.
// Configuration: cfg_we/cfg_data load the external requester's steal seed;
// write it only while the block is idle. A zero seed loads as one.
// A submit goes from accept through the decision step to the finishing step;
// a fetch from the own deque or the FIFO adds a read-capture step, and a steal
// scan tests one peer slot per step before the capture (on a hit) or the finish.
// A fetch that finds no work without scanning goes straight to the finish.
// One request is handled at a time; the next word is accepted in the cycle
// after the result loads.
// The result sits in an output register; the next request is accepted while
// it waits, and only the finishing step holds until the register is free.
// Reset (rst, synchronous) empties all deques and the FIFO and reloads seeds;
// token memories are not cleared, no clearing pass is needed.
module work_stealing_task_scheduler_unit
  import wsts_pkg::*;
#(
  parameter int NumWorkers = NumWorkersDef,
  parameter int DequeDepth = DequeDepthDef,
  parameter int ExtDepth   = ExtDepthDef,
  parameter int TokenWidth = TokenWidthDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // opcode, from_worker, requester_id[1:0], task_token[31:0], pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // status[1:0], task_found[31:0], source[1:0], victim_id[1:0], pad
  input  logic        cfg_we,
  input  logic [31:0] cfg_data
);
  wsts_cmd_t   cmd;
  wsts_sts_t   sts;
  logic        res_load;
  logic        out_free;
  logic [1:0]  res_status, res_source, res_victim;
  logic [31:0] res_task;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  wsts_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .res_load(res_load), .out_free(out_free),
    .cmd(cmd), .sts(sts)
  );

  wsts_dp #(
    .NumWorkers(NumWorkers), .DequeDepth(DequeDepth),
    .ExtDepth(ExtDepth), .TokenWidth(TokenWidth)
  ) u_dp (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .op_in(s_axis_tdata[0]), .from_worker_in(s_axis_tdata[1]),
    .requester_id_in(s_axis_tdata[3:2]), .token_in(s_axis_tdata[35:4]),
    .cmd(cmd), .sts(sts),
    .res_status(res_status), .res_task(res_task),
    .res_source(res_source), .res_victim(res_victim)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  assign m_axis_tdata = {2'b00, res_victim, res_source, res_task, res_status};

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result loaded over a waiting word");
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[1:0] != ST_OK) |-> (m_axis_tdata[33:2] == '0))
    else $error("failed request carries a token");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.latch_req, cmd.decide, cmd.steal_step, cmd.capture, cmd.finish}))
    else $error("controller issued overlapping commands");
`endif
endmodule

// ===== rtl/wsts_ram.sv =====
module wsts_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/wsts_ctrl.sv =====
module wsts_ctrl
  import wsts_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      res_load,
  input  logic      out_free,
  output wsts_cmd_t cmd,
  input  wsts_sts_t sts
);
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECIDE = 5'b00010,
    S_STEAL  = 5'b00100,
    S_READ   = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    res_load = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_req = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        priority if (sts.go_steal) begin
          state_next = S_STEAL;
        end else if (sts.need_read) begin
          state_next = S_READ;
        end else begin
          state_next = S_DONE;
        end
      end
      S_STEAL: begin
        cmd.steal_step = 1'b1;
        priority if (sts.steal_hit) begin
          state_next = S_READ;
        end else if (sts.steal_done) begin
          state_next = S_DONE;
        end
      end
      S_READ: begin
        // registered read data is valid in this cycle
        cmd.capture = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          res_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// ===== rtl/wsts_dp.sv =====
module wsts_dp
  import wsts_pkg::*;
#(
  parameter int NumWorkers = NumWorkersDef,
  parameter int DequeDepth = DequeDepthDef,
  parameter int ExtDepth   = ExtDepthDef,
  parameter int TokenWidth = TokenWidthDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic        op_in,
  input  logic        from_worker_in,
  input  logic [1:0]  requester_id_in,
  input  logic [31:0] token_in,
  input  wsts_cmd_t   cmd,
  output wsts_sts_t   sts,
  output logic [1:0]  res_status,
  output logic [31:0] res_task,
  output logic [1:0]  res_source,
  output logic [1:0]  res_victim
);
  localparam int WIdW  = (NumWorkers > 1) ? $clog2(NumWorkers) : 1;
  localparam int DIdxW = $clog2(DequeDepth);
  localparam int DPtrW = DIdxW + 1;
  localparam int EIdxW = $clog2(ExtDepth);
  localparam int ECntW = EIdxW + 1;
  localparam int DAddrW = $clog2(NumWorkers * DequeDepth);
  localparam int SeedN = NumWorkers + 1;
  localparam int SIdxW = $clog2(SeedN);
  localparam logic [DPtrW-1:0] DqFull = DPtrW'(DequeDepth);
  localparam logic [ECntW-1:0] ExtFull = ECntW'(ExtDepth);

  // request
  logic                  op;
  logic                  is_worker;
  logic [WIdW-1:0]       wid;
  logic [TokenWidth-1:0] tok;

  logic [DPtrW-1:0] dq_bot [NumWorkers];
  logic [DPtrW-1:0] dq_top [NumWorkers];
  logic [EIdxW-1:0] ext_head, ext_tail;
  logic [ECntW-1:0] ext_count;
  logic [31:0]      seed [SeedN];

  // scan state
  logic [WIdW-1:0] scan_v;
  logic [4:0]      scan_left;
  logic            rd_ext;
  logic [1:0]      pend_status, pend_source;
  logic [WIdW-1:0] pend_victim;
  logic [TokenWidth-1:0] pend_task;

  // memory ports
  logic                  dq_we, ex_we;
  logic [DAddrW-1:0]     dq_waddr, dq_raddr;
  logic [EIdxW-1:0]      ex_waddr, ex_raddr;
  logic [TokenWidth-1:0] dq_rdata, ex_rdata;

  logic [DPtrW-1:0] own_size, scan_size, own_bot_m1;
  logic [SIdxW-1:0] seed_sel;
  logic [31:0]      seed_new;
  logic [WIdW-1:0]  start;

  function automatic logic [DAddrW-1:0] dq_addr(input logic [WIdW-1:0] w,
                                                input logic [DPtrW-1:0] p);
    logic [DAddrW+DIdxW-1:0] a;
    a = (DAddrW+DIdxW)'(w) * (DAddrW+DIdxW)'(DequeDepth) + (DAddrW+DIdxW)'(p[DIdxW-1:0]);
    return a[DAddrW-1:0];
  endfunction

  assign own_size   = dq_bot[wid] - dq_top[wid];
  assign own_bot_m1 = dq_bot[wid] - 1'b1;
  assign scan_size  = dq_bot[scan_v] - dq_top[scan_v];
  assign seed_sel   = is_worker ? SIdxW'(wid) : SIdxW'(NumWorkers);
  assign seed_new   = xorshift32(seed[seed_sel]);
  assign start      = WIdW'(seed_new % 32'(NumWorkers));

  logic skip_self;
  assign skip_self = is_worker && (scan_v == wid);

  always_comb begin
    sts = '0;
    dq_we = 1'b0;
    ex_we = 1'b0;
    dq_waddr = dq_addr(wid, dq_bot[wid]);
    ex_waddr = ext_tail;
    dq_raddr = dq_addr(wid, own_bot_m1);
    ex_raddr = ext_head;
    if (cmd.decide) begin
      if (op == OP_SUBMIT) begin
        if (is_worker && own_size < DqFull) begin
          dq_we = 1'b1;
        end else if (ext_count < ExtFull) begin
          ex_we = 1'b1;
        end
      end else begin
        if (is_worker && own_size != '0) begin
          sts.need_read = 1'b1;
        end else if (ext_count != '0) begin
          sts.need_read = 1'b1;
        end else if (!is_worker || NumWorkers > 1) begin
          sts.go_steal = 1'b1;
        end
      end
    end
    if (cmd.steal_step) begin
      dq_raddr = dq_addr(scan_v, dq_top[scan_v]);
      if (scan_left == '0) begin
        sts.steal_done = 1'b1;
      end else if (!skip_self && scan_size != '0) begin
        sts.steal_hit = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumWorkers; i++) begin
        dq_bot[i] <= '0;
        dq_top[i] <= '0;
        seed[i] <= 32'((i + 1) * SeedMul);
      end
      seed[NumWorkers] <= 32'd1;
      ext_head <= '0;
      ext_tail <= '0;
      ext_count <= '0;
    end else begin
      if (cfg_we) begin
        seed[NumWorkers] <= (cfg_data == '0) ? 32'd1 : cfg_data;
      end
      if (cmd.decide) begin
        if (op == OP_SUBMIT) begin
          if (is_worker && own_size < DqFull) begin
            dq_bot[wid] <= dq_bot[wid] + 1'b1;
          end else if (ext_count < ExtFull) begin
            ext_tail <= (ext_tail == EIdxW'(ExtDepth - 1)) ? '0 : ext_tail + 1'b1;
            ext_count <= ext_count + 1'b1;
          end
        end else begin
          if (is_worker && own_size != '0) begin
            dq_bot[wid] <= own_bot_m1;
          end else if (ext_count != '0) begin
            ext_head <= (ext_head == EIdxW'(ExtDepth - 1)) ? '0 : ext_head + 1'b1;
            ext_count <= ext_count - 1'b1;
          end else if (!is_worker || NumWorkers > 1) begin
            seed[seed_sel] <= seed_new;
          end
        end
      end
      if (cmd.steal_step && scan_left != '0 && !skip_self && scan_size != '0) begin
        dq_top[scan_v] <= dq_top[scan_v] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      op <= op_in;
      is_worker <= from_worker_in && (32'(requester_id_in) < 32'(NumWorkers));
      wid <= WIdW'(requester_id_in);
      tok <= TokenWidth'(token_in);
    end
    if (cmd.decide) begin
      scan_v <= start;
      scan_left <= 5'(NumWorkers);
      pend_victim <= '0;
      rd_ext <= 1'b0;
      pend_source <= SRC_OWN;
      pend_status <= ST_EMPTY;
      if (op == OP_SUBMIT) begin
        if (is_worker && own_size < DqFull) begin
          pend_status <= ST_OK;
        end else if (ext_count < ExtFull) begin
          pend_status <= ST_OK;
          pend_source <= SRC_EXT;
        end else begin
          pend_status <= ST_REJECT;
        end
      end else if (is_worker && own_size != '0) begin
        pend_status <= ST_OK;
      end else if (ext_count != '0) begin
        pend_status <= ST_OK;
        pend_source <= SRC_EXT;
        rd_ext <= 1'b1;
      end
    end
    if (cmd.steal_step && scan_left != '0) begin
      if (!skip_self && scan_size != '0) begin
        pend_status <= ST_OK;
        pend_source <= SRC_STEAL;
        pend_victim <= scan_v;
      end
      scan_v <= (32'(scan_v) == NumWorkers - 1) ? '0 : scan_v + 1'b1;
      scan_left <= scan_left - 1'b1;
    end
    if (cmd.capture) begin
      pend_task <= rd_ext ? ex_rdata : dq_rdata;
    end
    if (cmd.finish) begin
      res_status <= pend_status;
      res_source <= (pend_status == ST_OK) ? pend_source : SRC_OWN;
      res_victim <= 2'(pend_victim);
      if (pend_status == ST_OK && op == OP_FETCH) begin
        res_task <= 32'(pend_task);
      end else begin
        res_task <= '0;
      end
    end
  end

  wsts_ram #(.Width(TokenWidth), .Depth(NumWorkers * DequeDepth)) u_dq_ram (
    .clk(clk), .we(dq_we), .waddr(dq_waddr), .wdata(tok),
    .raddr(dq_raddr), .rdata(dq_rdata)
  );

  wsts_ram #(.Width(TokenWidth), .Depth(ExtDepth)) u_ext_ram (
    .clk(clk), .we(ex_we), .waddr(ex_waddr), .wdata(tok),
    .raddr(ex_raddr), .rdata(ex_rdata)
  );
endmodule
